### hw/rtl/sicxe_instruction_executor_macros.svh
// Assertion macros shared by the executor RTL.
`ifndef SICXE_INSTRUCTION_EXECUTOR_MACROS_SVH
`define SICXE_INSTRUCTION_EXECUTOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SXE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SXE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/sxe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sxe_pkg
// Types and codes shared by the SIC/XE executor modules.
// ----------------------------------------------------------------------------
package sxe_pkg;

    localparam int SXE_MEM_BYTES = 65536;

    // item kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_START = 2'd2;
    localparam logic [1:0] KIND_STEP  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_START  = 2'd0;
    localparam logic [1:0] CFG_LENGTH = 2'd1;
    localparam logic [1:0] CFG_EXEC   = 2'd2;

    // opcodes
    localparam logic [7:0] OP_CLEAR = 8'hB4;
    localparam logic [7:0] OP_COMPR = 8'hA0;
    localparam logic [7:0] OP_TIXR  = 8'hB8;
    localparam logic [7:0] OP_LDA   = 8'h00;
    localparam logic [7:0] OP_LDB   = 8'h68;
    localparam logic [7:0] OP_LDT   = 8'h74;
    localparam logic [7:0] OP_LDCH  = 8'h50;
    localparam logic [7:0] OP_STA   = 8'h0C;
    localparam logic [7:0] OP_STX   = 8'h10;
    localparam logic [7:0] OP_STL   = 8'h14;
    localparam logic [7:0] OP_STCH  = 8'h54;
    localparam logic [7:0] OP_J     = 8'h3C;
    localparam logic [7:0] OP_JSUB  = 8'h48;
    localparam logic [7:0] OP_JLT   = 8'h38;
    localparam logic [7:0] OP_JEQ   = 8'h30;
    localparam logic [7:0] OP_RSUB  = 8'h4C;
    localparam logic [7:0] OP_COMP  = 8'h28;
    localparam logic [7:0] OP_TD    = 8'hE0;
    localparam logic [7:0] OP_RD    = 8'hD8;
    localparam logic [7:0] OPC_MASK = 8'hFC;

    // register numbers
    localparam logic [3:0] REG_A  = 4'd0;
    localparam logic [3:0] REG_X  = 4'd1;
    localparam logic [3:0] REG_L  = 4'd2;
    localparam logic [3:0] REG_B  = 4'd3;
    localparam logic [3:0] REG_S  = 4'd4;
    localparam logic [3:0] REG_T  = 4'd5;
    localparam logic [3:0] REG_PC = 4'd8;
    localparam logic [3:0] REG_SW = 4'd9;

    localparam logic [1:0] CC_LESS    = 2'b11;
    localparam logic [1:0] CC_EQUAL   = 2'b00;
    localparam logic [1:0] CC_GREATER = 2'b01;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_END    = 2'd1,
        STAT_BADOP  = 2'd2,
        STAT_BADREG = 2'd3
    } status_t;

    typedef enum logic {
        ALU_ADD,
        ALU_CMP
    } alu_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RDWAIT,
        ST_RESP,
        ST_FETCH,
        ST_DECODE,
        ST_F2_CLR,
        ST_F2_X,
        ST_F2_A,
        ST_F2_B,
        ST_TGT,
        ST_TGTX,
        ST_PTR,
        ST_OPND,
        ST_EXEC,
        ST_STORE
    } state_t;

endpackage

### hw/rtl/sxe_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sxe_mem
// Single-port byte memory with registered read data.
// ----------------------------------------------------------------------------
module sxe_mem #(
    parameter int MEM_BYTES = 65536,
    parameter int AW        = 16
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [7:0]    wdata,
    output logic [7:0]    rdata
);

    logic [7:0] mem [0:MEM_BYTES-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

### hw/rtl/sxe_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sxe_alu
// Shared 32-bit adder and signed comparator.
// ----------------------------------------------------------------------------
module sxe_alu (
    input  sxe_pkg::alu_op_t op,
    input  logic [31:0]      a,
    input  logic [31:0]      b,
    output logic [31:0]      sum,
    output logic [1:0]       cc
);

    import sxe_pkg::*;

    always_comb
    begin
        sum = 32'd0;
        cc  = CC_EQUAL;
        case (op)
            ALU_ADD: sum = a + b;
            ALU_CMP:
            begin
                if ($signed(a) < $signed(b))
                begin
                    cc = CC_LESS;
                end
                else if (a == b)
                begin
                    cc = CC_EQUAL;
                end
                else
                begin
                    cc = CC_GREATER;
                end
            end
            default: sum = 32'd0;
        endcase
    end

endmodule

### hw/rtl/sicxe_instruction_executor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sicxe_instruction_executor
// Subset SIC/XE executor: byte memory, register file and one-instruction step.
// ----------------------------------------------------------------------------
// Rate: one item at a time; input ready drops until its result is taken.
// Every byte moves through the single memory port, one per cycle (four-byte
// instruction fetch, then pointer and operand bytes, stores of 1, 3 or 4 bytes),
// and all 32-bit adds and compares share one ALU, one operation per cycle.
// A step at the program end answers without a fetch.
`include "sicxe_instruction_executor_macros.svh"

module sicxe_instruction_executor #(
    parameter int MEM_BYTES = sxe_pkg::SXE_MEM_BYTES
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [23:0]  s_axis_tdata,   // address[15:0], data[23:16]
    input  logic [1:0]   s_axis_tuser,   // kind[1:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[1:0], pc_value[17:2], acc_value[49:18], index_value[81:50],
    // link_value[113:82], base_value[145:114], sreg_value[177:146],
    // treg_value[209:178], cond_code[211:210], read_byte[219:212], zero pad
    output logic [223:0] m_axis_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    import sxe_pkg::*;

    localparam int AW = $clog2(MEM_BYTES);

    state_t state_reg, state_next;

    logic [31:0] a_reg, a_next, x_reg, x_next, l_reg, l_next, b_reg, b_next;
    logic [31:0] s_reg, s_next, t_reg, t_next, pc_reg, pc_next;
    logic [1:0]  sw_reg, sw_next;
    logic [15:0] start_reg, len_reg, exec_reg;
    logic [31:0] instr_reg, instr_next, tgt_reg, tgt_next, op_reg, op_next;
    logic [31:0] tmp_reg, tmp_next;
    status_t     status_reg, status_next;
    logic [7:0]  rbyte_reg, rbyte_next;
    logic [AW-1:0] ld_addr_reg, ld_addr_next;
    logic [2:0]  ld_cnt_reg, ld_cnt_next;
    logic [31:0] ld_word_reg, ld_word_next;
    logic [2:0]  st_cnt_reg, st_cnt_next;
    logic [31:0] st_data_reg, st_data_next;

    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wdata, mem_rdata;

    alu_op_t     alu_op;
    logic [31:0] alu_a, alu_b, alu_sum;
    logic [1:0]  alu_cc;

    logic        s_accept;
    logic [1:0]  in_kind;
    logic [15:0] in_addr;
    logic [7:0]  in_data;
    logic [16:0] prog_end;
    logic        at_end;

    logic [7:0]  b0, b1, opc;
    logic [3:0]  r1, r2, sel_a, sel_b, rd_idx;
    logic        f4, n_f, i_f, x_f, b_f, p_f, is_fmt2, bad_r1, bad_r2;
    logic [2:0]  len3, ld_len, st_len;
    logic [31:0] disp, base_sel, rd_data, ld_shift;
    logic        ld_done, ld_state;
    logic [7:0]  ch_byte;

    // ------------------------------------------------------------------
    assign in_kind  = s_axis_tuser;
    assign in_addr  = s_axis_tdata[15:0];
    assign in_data  = s_axis_tdata[23:16];
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept = s_axis_tvalid && s_axis_tready;
    assign cfg_ready = 1'b1;
    assign m_axis_tvalid = (state_reg == ST_RESP);
    assign m_axis_tdata = {4'd0, rbyte_reg, sw_reg, t_reg, s_reg, b_reg, l_reg,
                           x_reg, a_reg, pc_reg[15:0], status_reg};

    assign prog_end = {1'b0, start_reg} + {1'b0, len_reg};
    assign at_end   = (pc_reg == {15'd0, prog_end});

    assign b0  = instr_reg[31:24];
    assign b1  = instr_reg[23:16];
    assign opc = b0 & OPC_MASK;
    assign r1  = b1[7:4];
    assign r2  = b1[3:0];
    assign f4  = b1[4];
    assign n_f = b0[1];
    assign i_f = b0[0];
    assign x_f = b1[7];
    assign b_f = b1[6];
    assign p_f = b1[5];
    assign is_fmt2 = (b0[7:4] == 4'd9) || (b0[7:4] == 4'd10) || (b0[7:4] == 4'd11);
    assign bad_r1 = (r1 > REG_SW);
    assign bad_r2 = (r2 > REG_SW);
    assign len3 = f4 ? 3'd4 : 3'd3;
    assign disp = f4 ? {{12{instr_reg[19]}}, instr_reg[19:0]}
                     : {{20{instr_reg[19]}}, instr_reg[19:8]};
    // TIXR compares X with r1, COMPR compares r1 with r2
    assign sel_a = (b0 == OP_TIXR) ? REG_X : r1;
    assign sel_b = (b0 == OP_TIXR) ? r1 : r2;
    assign rd_idx = (state_reg == ST_F2_A) ? sel_a : sel_b;
    assign ch_byte = !n_f ? op_reg[7:0] : (f4 ? op_reg[31:24] : op_reg[23:16]);
    assign st_len = (opc == OP_STCH) ? 3'd1 : len3;

    always_comb
    begin
        if (p_f)
        begin
            base_sel = pc_reg;
        end
        else if (b_f)
        begin
            base_sel = b_reg;
        end
        else if (n_f && (i_f || !f4))
        begin
            base_sel = {16'd0, start_reg};
        end
        else
        begin
            base_sel = 32'd0;
        end
    end

    always_comb
    begin
        case (rd_idx)
            REG_A:   rd_data = a_reg;
            REG_X:   rd_data = x_reg;
            REG_L:   rd_data = l_reg;
            REG_B:   rd_data = b_reg;
            REG_S:   rd_data = s_reg;
            REG_T:   rd_data = t_reg;
            REG_PC:  rd_data = pc_reg;
            REG_SW:  rd_data = {{30{sw_reg[1]}}, sw_reg};
            default: rd_data = 32'd0;
        endcase
    end

    // byte loader: address issued at count k, data back at k+1
    assign ld_state = (state_reg == ST_FETCH) || (state_reg == ST_PTR) ||
                      (state_reg == ST_OPND);
    assign ld_len   = (state_reg == ST_FETCH) ? 3'd4 : len3;
    assign ld_done  = (ld_cnt_reg == ld_len);
    assign ld_shift = {ld_word_reg[23:0], mem_rdata};

    sxe_mem #(
        .MEM_BYTES (MEM_BYTES),
        .AW        (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    sxe_alu u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .sum (alu_sum),
        .cc  (alu_cc)
    );

    // ------------------------------------------------------------------
    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    unique case (in_kind)
                        KIND_READ:  state_next = ST_RDWAIT;
                        KIND_STEP:  state_next = at_end ? ST_RESP : ST_FETCH;
                        default:    state_next = ST_RESP;
                    endcase
                end
            end
            ST_RDWAIT: state_next = ST_RESP;
            ST_RESP:
            begin
                if (m_axis_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FETCH:
            begin
                if (ld_done)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (!is_fmt2)
                begin
                    state_next = ST_TGT;
                end
                else if (b0 == OP_CLEAR)
                begin
                    state_next = bad_r1 ? ST_RESP : ST_F2_CLR;
                end
                else if (b0 == OP_COMPR)
                begin
                    state_next = (bad_r1 || bad_r2) ? ST_RESP : ST_F2_A;
                end
                else if (b0 == OP_TIXR)
                begin
                    state_next = ST_F2_X;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_F2_CLR: state_next = ST_RESP;
            ST_F2_X:   state_next = bad_r1 ? ST_RESP : ST_F2_A;
            ST_F2_A:   state_next = ST_F2_B;
            ST_F2_B:   state_next = ST_RESP;
            ST_TGT:
            begin
                if (!n_f)
                begin
                    state_next = ST_EXEC;
                end
                else if (x_f)
                begin
                    state_next = ST_TGTX;
                end
                else
                begin
                    state_next = i_f ? ST_OPND : ST_PTR;
                end
            end
            ST_TGTX: state_next = i_f ? ST_OPND : ST_PTR;
            ST_PTR:
            begin
                if (ld_done)
                begin
                    state_next = ST_OPND;
                end
            end
            ST_OPND:
            begin
                if (ld_done)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if ((opc == OP_STA) || (opc == OP_STX) || (opc == OP_STL) ||
                    (opc == OP_STCH))
                begin
                    state_next = ST_STORE;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_STORE:
            begin
                if (st_cnt_reg == st_len - 3'd1)
                begin
                    state_next = ST_RESP;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // datapath
    always_comb
    begin
        a_next = a_reg;
        x_next = x_reg;
        l_next = l_reg;
        b_next = b_reg;
        s_next = s_reg;
        t_next = t_reg;
        pc_next = pc_reg;
        sw_next = sw_reg;
        instr_next = instr_reg;
        tgt_next = tgt_reg;
        op_next = op_reg;
        tmp_next = tmp_reg;
        status_next = status_reg;
        rbyte_next = rbyte_reg;
        ld_addr_next = ld_addr_reg;
        ld_cnt_next = 3'd0;
        ld_word_next = 32'd0;
        st_cnt_next = st_cnt_reg;
        st_data_next = st_data_reg;
        mem_we = 1'b0;
        mem_addr = ld_addr_reg + AW'(ld_cnt_reg);
        mem_wdata = st_data_reg[31:24];
        alu_op = ALU_ADD;
        alu_a = 32'd0;
        alu_b = 32'd0;

        if (ld_state && !ld_done)
        begin
            ld_cnt_next = ld_cnt_reg + 3'd1;
            ld_word_next = (ld_cnt_reg != 3'd0) ? ld_shift : ld_word_reg;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                mem_addr = AW'({16'd0, in_addr});
                ld_addr_next = pc_reg[AW-1:0];
                if (s_accept)
                begin
                    status_next = STAT_OK;
                    rbyte_next = 8'd0;
                    unique case (in_kind)
                        KIND_WRITE:
                        begin
                            mem_we = 1'b1;
                            mem_wdata = in_data;
                        end
                        KIND_START:
                        begin
                            l_next = {15'd0, prog_end};
                            pc_next = {16'd0, exec_reg};
                        end
                        KIND_STEP:
                        begin
                            if (at_end)
                            begin
                                a_next = 32'd0;
                                x_next = 32'd0;
                                l_next = 32'd0;
                                b_next = 32'd0;
                                s_next = 32'd0;
                                t_next = 32'd0;
                                pc_next = 32'd0;
                                sw_next = CC_EQUAL;
                                status_next = STAT_END;
                            end
                        end
                        default: rbyte_next = 8'd0;
                    endcase
                end
            end
            ST_RDWAIT: rbyte_next = mem_rdata;
            ST_FETCH:
            begin
                if (ld_done)
                begin
                    instr_next = ld_shift;
                end
            end
            ST_DECODE:
            begin
                alu_a = pc_reg;
                alu_b = is_fmt2 ? 32'd2 : {29'd0, len3};
                pc_next = alu_sum;
                if (is_fmt2)
                begin
                    if ((b0 == OP_CLEAR && bad_r1) ||
                        (b0 == OP_COMPR && (bad_r1 || bad_r2)))
                    begin
                        status_next = STAT_BADREG;
                    end
                    else if (b0 != OP_CLEAR && b0 != OP_COMPR && b0 != OP_TIXR)
                    begin
                        status_next = STAT_BADOP;
                    end
                end
            end
            ST_F2_CLR:
            begin
                case (r1)
                    REG_A:  a_next = 32'd0;
                    REG_X:  x_next = 32'd0;
                    REG_L:  l_next = 32'd0;
                    REG_B:  b_next = 32'd0;
                    REG_S:  s_next = 32'd0;
                    REG_T:  t_next = 32'd0;
                    REG_PC: pc_next = 32'd0;
                    REG_SW: sw_next = CC_EQUAL;
                    default: sw_next = sw_reg;
                endcase
            end
            ST_F2_X:
            begin
                alu_a = x_reg;
                alu_b = 32'd1;
                x_next = alu_sum;
                if (bad_r1)
                begin
                    status_next = STAT_BADREG;
                end
            end
            ST_F2_A: tmp_next = rd_data;
            ST_F2_B:
            begin
                alu_op = ALU_CMP;
                alu_a = tmp_reg;
                alu_b = rd_data;
                sw_next = alu_cc;
            end
            ST_TGT:
            begin
                alu_a = disp;
                alu_b = base_sel;
                tgt_next = alu_sum;
                op_next = alu_sum;
                ld_addr_next = alu_sum[AW-1:0];
            end
            ST_TGTX:
            begin
                alu_a = tgt_reg;
                alu_b = x_reg;
                tgt_next = alu_sum;
                ld_addr_next = alu_sum[AW-1:0];
            end
            ST_PTR:
            begin
                if (ld_done)
                begin
                    tgt_next = ld_shift;
                    ld_addr_next = ld_shift[AW-1:0];
                end
            end
            ST_OPND:
            begin
                if (ld_done)
                begin
                    op_next = ld_shift;
                end
            end
            ST_EXEC:
            begin
                alu_op = ALU_CMP;
                alu_a = a_reg;
                alu_b = op_reg;
                st_cnt_next = 3'd0;
                case (opc)
                    OP_LDA:  a_next = op_reg;
                    OP_LDB:  b_next = op_reg;
                    OP_LDT:  t_next = op_reg;
                    OP_LDCH: a_next = {8'd0, a_reg[23:8], ch_byte};
                    OP_STA:  st_data_next = f4 ? a_reg : {a_reg[23:0], 8'd0};
                    OP_STX:  st_data_next = f4 ? x_reg : {x_reg[23:0], 8'd0};
                    OP_STL:  st_data_next = f4 ? l_reg : {l_reg[23:0], 8'd0};
                    OP_STCH: st_data_next = {a_reg[7:0], 24'd0};
                    OP_J:    pc_next = tgt_reg;
                    OP_JSUB:
                    begin
                        l_next = pc_reg;
                        pc_next = tgt_reg;
                    end
                    OP_JLT:
                    begin
                        if (sw_reg == CC_LESS)
                        begin
                            pc_next = tgt_reg;
                        end
                    end
                    OP_JEQ:
                    begin
                        if (sw_reg == CC_EQUAL)
                        begin
                            pc_next = tgt_reg;
                        end
                    end
                    OP_RSUB: pc_next = l_reg;
                    OP_COMP: sw_next = alu_cc;
                    OP_TD:   sw_next = CC_LESS;
                    OP_RD:   sw_next = CC_EQUAL;
                    default: sw_next = sw_reg;
                endcase
            end
            ST_STORE:
            begin
                mem_we = 1'b1;
                mem_addr = tgt_reg[AW-1:0] + AW'(st_cnt_reg);
                st_cnt_next = st_cnt_reg + 3'd1;
                st_data_next = {st_data_reg[23:0], 8'd0};
            end
            default: rbyte_next = rbyte_reg;
        endcase
    end

    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            a_reg      <= 32'd0;
            x_reg      <= 32'd0;
            l_reg      <= 32'd0;
            b_reg      <= 32'd0;
            s_reg      <= 32'd0;
            t_reg      <= 32'd0;
            pc_reg     <= 32'd0;
            sw_reg     <= CC_EQUAL;
            start_reg  <= 16'd0;
            len_reg    <= 16'd0;
            exec_reg   <= 16'd0;
            status_reg <= STAT_OK;
            rbyte_reg  <= 8'd0;
            ld_cnt_reg <= 3'd0;
            st_cnt_reg <= 3'd0;
        end
        else
        begin
            state_reg  <= state_next;
            a_reg      <= a_next;
            x_reg      <= x_next;
            l_reg      <= l_next;
            b_reg      <= b_next;
            s_reg      <= s_next;
            t_reg      <= t_next;
            pc_reg     <= pc_next;
            sw_reg     <= sw_next;
            status_reg <= status_next;
            rbyte_reg  <= rbyte_next;
            ld_cnt_reg <= ld_cnt_next;
            st_cnt_reg <= st_cnt_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_START:  start_reg <= cfg_data;
                    CFG_LENGTH: len_reg   <= cfg_data;
                    CFG_EXEC:   exec_reg  <= cfg_data;
                    default:    exec_reg  <= exec_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        instr_reg   <= instr_next;
        tgt_reg     <= tgt_next;
        op_reg      <= op_next;
        tmp_reg     <= tmp_next;
        ld_addr_reg <= ld_addr_next;
        ld_word_reg <= ld_word_next;
        st_data_reg <= st_data_next;
    end

    // ------------------------------------------------------------------
    `SXE_ASSERT_NOW(a_one_item, clk, rst_n, m_axis_tvalid, !s_axis_tready, "input taken while a result waits")
    `SXE_ASSERT_NEXT(a_back_idle, clk, rst_n, m_axis_tvalid && m_axis_tready, s_axis_tready, "not ready after result taken")
    `SXE_ASSERT_NOW(a_end_clear, clk, rst_n, m_axis_tvalid && status_reg == STAT_END, pc_reg == 32'd0 && a_reg == 32'd0 && l_reg == 32'd0, "end did not clear registers")
    `SXE_ASSERT_NOW(a_cc_legal, clk, rst_n, m_axis_tvalid, sw_reg != 2'b10, "illegal condition code")
    `SXE_ASSERT_NOW(a_mem_write, clk, rst_n, mem_we, state_reg == ST_IDLE || state_reg == ST_STORE, "memory write outside write or store")

endmodule
